/* sv/assert_macros.svh */
// Assertion macros shared by the detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("label");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("label");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* sv/lozd_pkg.sv */
// Shared types and constants of the lidar obstacle zone detector.
package lozd_pkg;
	localparam int MaxBeams = 2048;
	localparam int TrigFracBits = 15;
	localparam int Iters = TrigFracBits + 1;
	localparam int IterW = $clog2(Iters + 1);
	localparam int AccW = 40;
	localparam int KQ = (652032874 + (1 << (29 - TrigFracBits))) >> (30 - TrigFracBits);

	localparam logic [2:0] REG_YAW = 3'd0;
	localparam logic [2:0] REG_SIDE = 3'd1;
	localparam logic [2:0] REG_START = 3'd2;
	localparam logic [2:0] REG_STEP = 3'd3;
	localparam logic [2:0] REG_FWD = 3'd4;
	localparam logic [2:0] REG_NEAR = 3'd5;
	localparam logic [2:0] REG_FAR = 3'd6;
	localparam logic [2:0] REG_THR = 3'd7;

	localparam logic [1:0] SIDE_RIGHT = 2'd1;
	localparam logic [1:0] SIDE_LEFT = 2'd2;

	typedef enum logic [2:0] {ST_IDLE, ST_PHASE, ST_LOAD, ST_ITER, ST_ROUND, ST_OUT} state_t;

	typedef struct packed {
		logic capture;
		logic phase;
		logic load;
		logic iter;
		logic round;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic iter_done;
	} sts_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] t;
		unique case (i)
			5'd0: t = 32'h20000000; 5'd1: t = 32'h12E4051E; 5'd2: t = 32'h09FB385B;
			5'd3: t = 32'h051111D4; 5'd4: t = 32'h028B0D43; 5'd5: t = 32'h0145D7E1;
			5'd6: t = 32'h00A2F61E; 5'd7: t = 32'h00517C55; 5'd8: t = 32'h0028BE53;
			5'd9: t = 32'h00145F2F; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
			5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
			5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
			5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
			5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
			default: t = 32'h0;
		endcase
		return t;
	endfunction
endpackage

/* sv/lidar_obstacle_zone_detector.sv */
// Per sample: capture, phase, load, a 16-step CORDIC loop, rounding, then output.
// A skipped sample goes from phase straight to rounding; the CORDIC loop sets the sample rate.
// One sample is in flight; the next is taken the cycle after the result transaction.
// Asynchronous active-low reset clears control, hit count and configuration registers to defaults.
// Top level of the lidar obstacle zone detector.
module lidar_obstacle_zone_detector import lozd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [31:0] s_axis_tdata, // range_mm[15:0], beam_index[26:16], point_valid[27]
	input logic s_axis_tlast,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [47:0] m_axis_tdata, // point_x[16:0], point_y[33:17], in_zone[34],
	                                  // zone_hits[46:35], obstacle_detected[47]
	output logic m_axis_tlast, // scan_done
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	logic [15:0] yaw, st, stp, fwd, nr, fr;
	logic [1:0] side;
	logic [10:0] thr;
	cmd_t cmd;
	sts_t sts;
	logic [48:0] res;

	lozd_cfg u_cfg (.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.mount_yaw(yaw), .sensor_side(side), .scan_start_angle(st), .scan_angle_step(stp),
		.forward_limit(fwd), .near_side_limit(nr), .far_side_limit(fr), .hit_threshold(thr));

	lozd_ctrl u_ctrl (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .sts, .cmd);

	lozd_dp u_dp (.clk, .arst_n, .cmd, .sts, .range_mm(s_axis_tdata[15:0]),
		.beam_index(s_axis_tdata[26:16]), .point_valid(s_axis_tdata[27]),
		.last_of_scan(s_axis_tlast), .mount_yaw(yaw), .sensor_side(side),
		.scan_start_angle(st), .scan_angle_step(stp), .forward_limit(fwd),
		.near_side_limit(nr), .far_side_limit(fr), .hit_threshold(thr), .res);

	// pull scan_done out of the result word into tlast
	assign m_axis_tdata = {res[48], res[47:36], res[34:0]};
	assign m_axis_tlast = res[35];
endmodule

/* sv/lozd_ctrl.sv */
// Controller sequencing one sample through phase, CORDIC, rounding and output.
`include "assert_macros.svh"
module lozd_ctrl import lozd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_PHASE;
				end
			end
			ST_PHASE: begin
				cmd.phase = 1'b1;
				state_d = sts.skip ? ST_ROUND : ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = ST_ITER;
			end
			ST_ITER: begin
				cmd.iter = 1'b1;
				if (sts.iter_done) state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// result register doubles as output; next sample waits for drain
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`ASSERT_IMPLIES(a_ready_idle, clk, arst_n, in_ready, !out_valid)
	`ASSERT_NEXT(a_cap_phase, clk, arst_n, cmd.capture, state_q == ST_PHASE)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

/* sv/lozd_dp.sv */
// Datapath: phase accumulate, iterative CORDIC, rounding, zone check, hit count.
`include "assert_macros.svh"
module lozd_dp import lozd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output sts_t sts,
	input logic [15:0] range_mm,
	input logic [10:0] beam_index,
	input logic point_valid,
	input logic last_of_scan,
	input logic [15:0] mount_yaw,
	input logic [1:0] sensor_side,
	input logic [15:0] scan_start_angle,
	input logic [15:0] scan_angle_step,
	input logic [15:0] forward_limit,
	input logic [15:0] near_side_limit,
	input logic [15:0] far_side_limit,
	input logic [10:0] hit_threshold,
	output logic [48:0] res
);
	logic [15:0] range_q;
	logic [10:0] idx_q;
	logic valid_q, last_q;
	logic [31:0] phase_q;
	logic signed [AccW-1:0] x_q, y_q, z_q;
	logic [IterW-1:0] it_q;
	logic [11:0] hits_q;
	logic signed [16:0] px_q, py_q;
	logic hit_q;

	logic [23:0] prod;
	logic [31:0] phase_d;
	logic signed [AccW-1:0] m, dx, dy, tab;
	logic signed [16:0] sx, sy;
	logic signed [17:0] xe, ye;
	logic hit_d;
	logic [11:0] hits_inc;

	// only the low 24 bits of index times step reach the phase
	assign prod = 24'(idx_q) * 24'(scan_angle_step);
	assign phase_d = {scan_start_angle, 16'h0} + {mount_yaw, 16'h0} + {prod, 8'h0};
	assign sts.skip = !valid_q || (32'(idx_q) >= 32'(MaxBeams));
	assign sts.iter_done = (it_q == IterW'(Iters - 1));

	assign m = AccW'(32'(range_q) * 32'(KQ));
	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign tab = AccW'(atan_lut(5'(it_q)));

	function automatic logic signed [16:0] to_mm(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] r;
		r = (v + AccW'(1 << (TrigFracBits - 1))) >>> TrigFracBits;
		if (r > AccW'(65535)) return 17'sd65535;
		else if (r < -AccW'(65536)) return -17'sd65536;
		return r[16:0];
	endfunction

	assign sx = to_mm(x_q);
	assign sy = to_mm(y_q);
	assign xe = 18'(sx);
	assign ye = 18'(sy);

	always_comb begin
		priority if (sensor_side == SIDE_RIGHT)
			hit_d = (xe < $signed({2'b0, forward_limit})) && (ye < $signed({2'b0, near_side_limit}))
				&& (ye > -$signed({2'b0, far_side_limit}));
		else if (sensor_side == SIDE_LEFT)
			hit_d = (xe < $signed({2'b0, forward_limit})) && (ye < $signed({2'b0, far_side_limit}))
				&& (ye > -$signed({2'b0, near_side_limit}));
		else hit_d = 1'b0;
		if (sts.skip) hit_d = 1'b0;
	end

	assign hits_inc = (hit_d && hits_q != 12'hFFF) ? hits_q + 12'd1 : hits_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			range_q <= range_mm;
			idx_q <= beam_index;
			valid_q <= point_valid;
			last_q <= last_of_scan;
		end
		if (cmd.phase) phase_q <= phase_d;
		if (cmd.load) begin
			unique case (phase_q[31:30])
				2'd0: begin x_q <= m; y_q <= '0; end
				2'd1: begin x_q <= '0; y_q <= m; end
				2'd2: begin x_q <= -m; y_q <= '0; end
				default: begin x_q <= '0; y_q <= -m; end
			endcase
			z_q <= AccW'(phase_q[29:0]);
			it_q <= '0;
		end
		if (cmd.iter) begin
			if (!z_q[AccW-1]) begin
				x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - tab;
			end else begin
				x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + tab;
			end
			it_q <= it_q + IterW'(1);
		end
		if (cmd.round) begin
			px_q <= sts.skip ? '0 : sx;
			py_q <= sts.skip ? '0 : sy;
			hit_q <= hit_d;
		end
	end

	// hit counter; cleared when the last beam's result leaves
	logic [11:0] hits_out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hits_q <= '0;
		else if (cmd.round) hits_q <= hits_inc;
		else if (cmd.finish && last_q) hits_q <= '0;
	end
	always_ff @(posedge clk) if (cmd.round) hits_out_q <= hits_inc;

	assign res = {(last_q && hits_out_q > {1'b0, hit_threshold}),
		last_q ? hits_out_q : 12'h0, last_q, hit_q, py_q, px_q};

	`ASSERT_NEXT(a_iter_bound, clk, arst_n, cmd.load, it_q == '0)
	`ASSERT_IMPLIES(a_skip_nohit, clk, arst_n, cmd.round && sts.skip, !hit_d)
	`ASSERT_NEXT(a_count_sat, clk, arst_n, cmd.round && hits_q == 12'hFFF, hits_q == 12'hFFF)
endmodule

/* sv/lozd_cfg.sv */
// Configuration register file.
module lozd_cfg import lozd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data,
	output logic [15:0] mount_yaw,
	output logic [1:0] sensor_side,
	output logic [15:0] scan_start_angle,
	output logic [15:0] scan_angle_step,
	output logic [15:0] forward_limit,
	output logic [15:0] near_side_limit,
	output logic [15:0] far_side_limit,
	output logic [10:0] hit_threshold
);
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_yaw <= 16'd0; sensor_side <= 2'd0; scan_start_angle <= 16'hA000;
			scan_angle_step <= 16'd16384; forward_limit <= 16'd1000;
			near_side_limit <= 16'd200; far_side_limit <= 16'd500; hit_threshold <= 11'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_YAW: mount_yaw <= cfg_data;
				REG_SIDE: sensor_side <= cfg_data[1:0];
				REG_START: scan_start_angle <= cfg_data;
				REG_STEP: scan_angle_step <= cfg_data;
				REG_FWD: forward_limit <= cfg_data;
				REG_NEAR: near_side_limit <= cfg_data;
				REG_FAR: far_side_limit <= cfg_data;
				REG_THR: hit_threshold <= cfg_data[10:0];
				default: ;
			endcase
		end
	end
endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the lidar obstacle zone detector: directed table, random scans.
`timescale 1ns / 1ps
module tb_top;
	import lozd_pkg::*;

	typedef struct {
		logic signed [16:0] x;
		logic signed [16:0] y;
		logic zone;
		logic done;
		logic [11:0] hits;
		logic obs;
	} point_res_t;

	typedef struct {
		logic [15:0] range_mm;
		logic [10:0] beam;
		logic valid;
		logic last;
		bit lit; // the point fields below are known by inspection
		logic signed [16:0] lit_x;
		logic signed [16:0] lit_y;
		logic lit_zone;
	} beam_row_t;

	localparam longint TIMEOUT_CYCLES = 2000000;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	lidar_obstacle_zone_detector dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// detector settings as the testbench tracks them
	logic [15:0] yaw_q, start_q, step_q, fwd_q, near_q, far_q;
	logic [1:0] side_q;
	logic [10:0] thr_q;
	logic [11:0] scan_hits;

	point_res_t pending_points[$];
	int errors = 0;
	int n_sent = 0, n_got = 0, n_hits = 0, n_scans = 0;
	bit rx_hold = 0;
	bit rx_steady = 0;
	longint cycles = 0;

	const logic [31:0] ARCTAN[16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_mm(longint v);
		longint r;
		r = (v + (longint'(1) <<< (TrigFracBits - 1))) >>> TrigFracBits;
		if (r > 65535) r = 65535;
		if (r < -65536) r = -65536;
		return r;
	endfunction

	// Compute one point and advance the scan hit count.
	function automatic point_res_t locate_point(logic [15:0] rng, logic [10:0] beam,
			logic valid, logic last);
		point_res_t r;
		logic [31:0] ph, prod;
		longint x, y, z, m, dx, dy, rx, ry;
		bit hit;
		r.x = 0; r.y = 0; r.zone = 0; hit = 0;
		if (valid && beam < MaxBeams) begin
			prod = 32'(beam) * 32'(step_q);
			ph = {start_q, 16'b0} + {yaw_q, 16'b0} + (prod << 8);
			m = longint'(rng) * longint'(KQ);
			case (ph[31:30])
				2'd0: begin x = m; y = 0; end
				2'd1: begin x = 0; y = m; end
				2'd2: begin x = -m; y = 0; end
				default: begin x = 0; y = -m; end
			endcase
			z = longint'(ph[29:0]);
			for (int i = 0; i < Iters; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(ARCTAN[i]);
				end else begin
					x += dx; y -= dy; z += longint'(ARCTAN[i]);
				end
			end
			rx = round_mm(x);
			ry = round_mm(y);
			if (side_q == SIDE_RIGHT)
				hit = rx < longint'(fwd_q) && ry < longint'(near_q) && ry > -longint'(far_q);
			else if (side_q == SIDE_LEFT)
				hit = rx < longint'(fwd_q) && ry < longint'(far_q) && ry > -longint'(near_q);
			if (hit && scan_hits != 12'hFFF) scan_hits++;
			r.x = rx[16:0];
			r.y = ry[16:0];
			r.zone = hit;
		end
		r.done = last;
		r.hits = last ? scan_hits : 12'd0;
		r.obs = last ? (scan_hits > thr_q) : 1'b0;
		if (last) scan_hits = 0;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 19);
		if (p < 12) return 0;
		if (p < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_beam(beam_row_t b);
		point_res_t e;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, b.valid, b.beam, b.range_mm};
		s_axis_tlast <= b.last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		e = locate_point(b.range_mm, b.beam, b.valid, b.last);
		if (b.lit && (e.x !== b.lit_x || e.y !== b.lit_y || e.zone !== b.lit_zone)) begin
			$display("%0t predictor disagrees with table: exp %0d %0d %0d got %0d %0d %0d",
				$time, b.lit_x, b.lit_y, b.lit_zone, e.x, e.y, e.zone);
			errors++;
		end
		pending_points.push_back(e);
		n_sent++;
		gap = rx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		// drop valid so the last transaction is not taken twice
		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_YAW: yaw_q = val;
			REG_SIDE: side_q = val[1:0];
			REG_START: start_q = val;
			REG_STEP: step_q = val;
			REG_FWD: fwd_q = val;
			REG_NEAR: near_q = val;
			REG_FAR: far_q = val;
			default: thr_q = val[10:0];
		endcase
	endtask

	task automatic load_settings(logic [15:0] v[8]);
		wait_idle();
		write_reg(REG_YAW, v[0]);
		write_reg(REG_SIDE, v[1]);
		write_reg(REG_START, v[2]);
		write_reg(REG_STEP, v[3]);
		write_reg(REG_FWD, v[4]);
		write_reg(REG_NEAR, v[5]);
		write_reg(REG_FAR, v[6]);
		write_reg(REG_THR, v[7]);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_beams(int count);
		beam_row_t b;
		int len;
		int done;
		done = 0;
		while (done < count) begin
			if ($urandom_range(0, 4) != 0) begin
				// well-formed scan: consecutive beams, last one flagged
				len = $urandom_range(1, 20);
				b.beam = 11'($urandom);
				for (int i = 0; i < len; i++) begin
					b.range_mm = $urandom_range(0, 1) ? 16'($urandom_range(0, 1500)) :
						16'($urandom);
					b.valid = $urandom_range(0, 9) != 0;
					b.last = (i == len - 1);
					b.lit = 0;
					send_beam(b);
					b.beam = b.beam + 11'd1;
				end
				done += len;
			end else begin
				b.range_mm = 16'($urandom);
				b.beam = 11'($urandom);
				b.valid = 1'($urandom);
				b.last = 1'($urandom);
				b.lit = 0;
				send_beam(b);
				done++;
			end
		end
	endtask

	// receiver: random stalls, optional long hold, checking
	always @(posedge clk) begin
		point_res_t e;
		static int rgap = 0;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_points.size() == 0) begin
				$display("%0t unexpected result tdata=%h tlast=%b", $time, m_axis_tdata,
					m_axis_tlast);
				errors++;
			end else begin
				e = pending_points.pop_front();
				n_got++;
				if (e.zone) n_hits++;
				if (e.done) n_scans++;
				if (m_axis_tdata[16:0] !== e.x || m_axis_tdata[33:17] !== e.y ||
						m_axis_tdata[34] !== e.zone || m_axis_tdata[46:35] !== e.hits ||
						m_axis_tlast !== e.done || m_axis_tdata[47] !== e.obs) begin
					$display("%0t mismatch exp x=%0d y=%0d zone=%b hits=%0d done=%b obs=%b",
						$time, e.x, e.y, e.zone, e.hits, e.done, e.obs);
					$display("%0t          got x=%0d y=%0d zone=%b hits=%0d done=%b obs=%b",
						$time, $signed(m_axis_tdata[16:0]), $signed(m_axis_tdata[33:17]),
						m_axis_tdata[34], m_axis_tdata[46:35], m_axis_tlast,
						m_axis_tdata[47]);
					errors++;
				end
			end
			rgap = rx_steady ? 0 : pick_gap();
		end
		if (rx_hold || rgap > 0) begin
			m_axis_tready <= 1'b0;
			if (!rx_hold) rgap--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// long receiver hold while the sender keeps offering
	initial begin
		@(posedge arst_n);
		while (n_sent < 120) @(posedge clk);
		rx_hold <= 1'b1;
		repeat (400) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		beam_row_t dir[$];
		logic [15:0] v[8];
		arst_n = 0;
		s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tlast = 0;
		m_axis_tready = 0;
		cfg_valid = 0; cfg_index = REG_YAW; cfg_data = 0;
		yaw_q = 0; side_q = 0; start_q = 16'(-24576); step_q = 16384;
		fwd_q = 1000; near_q = 200; far_q = 500; thr_q = 8; scan_hits = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under reset settings
		dir.push_back('{16'd0, 11'd0, 1'b1, 1'b0, 1, 17'sd0, 17'sd0, 1'b0});
		dir.push_back('{16'hFFFF, 11'd5, 1'b0, 1'b0, 1, 17'sd0, 17'sd0, 1'b0});
		dir.push_back('{16'hFFFF, 11'd2047, 1'b0, 1'b1, 1, 17'sd0, 17'sd0, 1'b0});
		dir.push_back('{16'd0, 11'd2047, 1'b1, 1'b1, 1, 17'sd0, 17'sd0, 1'b0});
		dir.push_back('{16'hFFFF, 11'd0, 1'b1, 1'b0, 0, 0, 0, 0});
		dir.push_back('{16'hFFFF, 11'd1, 1'b1, 1'b0, 0, 0, 0, 0});
		dir.push_back('{16'hFFFF, 11'd2, 1'b1, 1'b0, 0, 0, 0, 0});
		dir.push_back('{16'hFFFF, 11'd3, 1'b1, 1'b0, 0, 0, 0, 0});
		dir.push_back('{16'd300, 11'd2047, 1'b1, 1'b1, 0, 0, 0, 0});
		dir.push_back('{16'h5555, 11'h555, 1'b1, 1'b0, 0, 0, 0, 0});
		dir.push_back('{16'hAAAA, 11'h2AA, 1'b1, 1'b1, 0, 0, 0, 0});
		foreach (dir[i]) send_beam(dir[i]);

		// right side, wide zone, zero threshold: nearly every point is a hit
		v = '{16'd0, 16'(SIDE_RIGHT), 16'd0, 16'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0};
		load_settings(v);
		dir.delete();
		dir.push_back('{16'd100, 11'd0, 1'b1, 1'b0, 0, 0, 0, 0});
		dir.push_back('{16'd100, 11'd2047, 1'b1, 1'b0, 0, 0, 0, 0});
		dir.push_back('{16'd0, 11'd3, 1'b0, 1'b1, 0, 0, 0, 0});
		foreach (dir[i]) send_beam(dir[i]);
		rx_steady = 1;
		random_beams(60);
		rx_steady = 0;

		// left side with every limit at zero: no hits possible
		v = '{16'h8000, 16'(SIDE_LEFT), 16'h7FFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd2047};
		load_settings(v);
		random_beams(60);

		for (int ph = 0; ph < 4; ph++) begin
			v[0] = 16'($urandom); v[1] = 16'($urandom_range(0, 2)); v[2] = 16'($urandom);
			v[3] = 16'($urandom); v[4] = 16'($urandom_range(0, 3000));
			v[5] = 16'($urandom_range(0, 800));
			v[6] = 16'($urandom_range(0, 3000)); v[7] = 16'($urandom_range(0, 6));
			if (ph == 0) v[1] = 16'(SIDE_LEFT);
			if (ph == 1) v[1] = 16'(SIDE_RIGHT);
			load_settings(v);
			random_beams(70);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d samples in %0d config settings; %0d results checked.", n_sent, 7,
			n_got);
		$display("Zone hits seen: %0d, scans closed: %0d.", n_hits, n_scans);
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
